FILE: rtl/tmlux_pkg.sv
// ----------------------------------------------------------------------------
// tmlux_pkg
// Types and fixed constants shared by the lux scaler and its test bench.
// ----------------------------------------------------------------------------
package tmlux_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int TARGET_W  = 16;
    localparam int VALUE_W   = 32;
    localparam int CTR_W     = 5;   // counts the bits of a value word
    localparam int DROP_LOW  = 3;
    localparam int DROP_HIGH = 2;

    localparam logic KIND_CAL = 1'b0;
    localparam logic KIND_LUX = 1'b1;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [TARGET_W-1:0] target_t;
    typedef logic [VALUE_W-1:0]  value_t;

    typedef struct packed {
        logic    kind;
        sample_t sample;
    } in_word_t;

    typedef struct packed {
        logic   result_kind;
        value_t value;
        logic   error;
    } out_word_t;

endpackage

FILE: rtl/tmlux_chan_if.sv
// ----------------------------------------------------------------------------
// tmlux_chan_if
// Valid/ready channel carrying one word of any packed payload type.
// ----------------------------------------------------------------------------
interface tmlux_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/trimmed_mean_calibrated_lux_scaler.sv
// ----------------------------------------------------------------------------
// trimmed_mean_calibrated_lux_scaler
// Calibrates an ambient light sensor from a trimmed mean of samples and
// scales measurement samples to lux with a bit-serial multiply and divide.
// ----------------------------------------------------------------------------
//  channel | role   | word
//  --------+--------+-----------------------------------------------
//  smp     | sink   | kind (cal 0 / lux 1), sample[15:0]
//  res     | source | result_kind, value[31:0], error
//  cfg     | sink   | lux_target[15:0], always ready
//
// One word is worked on at a time; smp is ready only while the sequencer idles.
// Calibration word that does not fill the store: accepted while the sequencer stays idle.
// Word that fills the store: ranking through the rotating store, then the divider,
// then the load of the result register.
// Measurement word: shift-add multiply, then the divider, then the load;
// with a zero calibration value the error word goes straight to the load.
// Reset (rst_n, asynchronous) clears count, calibration value and control; the
// result register holds its word until res.ready, while the next word is taken;
// a further result waits in the load state until the register is free.
// ----------------------------------------------------------------------------
module trimmed_mean_calibrated_lux_scaler #(
    parameter int CAL_SAMPLES = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    tmlux_chan_if.sink         smp,
    tmlux_chan_if.source       res,
    tmlux_chan_if.sink         cfg
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int KEEP  = CAL_SAMPLES - tmlux_pkg::DROP_LOW - tmlux_pkg::DROP_HIGH;
    localparam int CNT_W = $clog2(CAL_SAMPLES);        // store position / rank
    localparam int JW    = $clog2(CAL_SAMPLES + 1);    // ranking step 0..N
    localparam int IJ_W  = JW + 1;                     // candidate + step
    localparam int SUM_W = tmlux_pkg::SAMPLE_W + $clog2(KEEP + 1);

    localparam int SW = tmlux_pkg::SAMPLE_W;
    localparam int VW = tmlux_pkg::VALUE_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RANK = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [2:0]                          state_reg,  state_next;
    logic [CNT_W-1:0]                    count_reg,  count_next;
    tmlux_pkg::sample_t                  cal_reg,    cal_next;
    tmlux_pkg::target_t                  target_reg, target_next;
    logic [tmlux_pkg::CTR_W-1:0]         ctr_reg,    ctr_next;
    logic [CNT_W-1:0]                    ci_reg,     ci_next;
    logic [JW-1:0]                       step_reg,   step_next;
    logic [CNT_W-1:0]                    rank_reg,   rank_next;
    logic                                res_valid_reg, res_valid_next;

    // Payload registers (no reset)
    tmlux_pkg::sample_t                  store_reg [CAL_SAMPLES];
    tmlux_pkg::sample_t                  cand_reg,   cand_next;
    logic [SUM_W-1:0]                    sum_reg,    sum_next;
    tmlux_pkg::sample_t                  mplr_reg,   mplr_next;
    tmlux_pkg::value_t                   dq_reg,     dq_next;
    tmlux_pkg::sample_t                  rem_reg,    rem_next;
    tmlux_pkg::sample_t                  dvsr_reg,   dvsr_next;
    logic                                kind_reg,   kind_next;
    logic                                err_reg,    err_next;
    tmlux_pkg::out_word_t                res_word_reg, res_word_next;

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic                  smp_acc;
    logic                  shift_in;     // shift a new calibration word into the store
    logic                  rotate;       // turn the store ring by one place
    logic                  earlier;      // tie break: compared entry sits earlier
    logic                  smaller;
    logic                  keep_cand;
    logic [SUM_W-1:0]      sum_add;
    logic [SW:0]           rem_sh;
    logic                  q_bit;
    tmlux_pkg::value_t     quot;
    logic                  res_load;

    assign smp_acc   = smp.valid && smp.ready;
    assign smp.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign shift_in = smp_acc && (smp.data.kind == tmlux_pkg::KIND_CAL);
    assign rotate   = (state_reg == ST_RANK);

    // Entry at offset step from candidate ci has original place ci+step mod N;
    // it comes first when that wraps.
    assign earlier = (IJ_W'(ci_reg) + IJ_W'(step_reg)) >= IJ_W'(CAL_SAMPLES);
    assign smaller = (store_reg[0] < cand_reg) || ((store_reg[0] == cand_reg) && earlier);

    assign keep_cand = (rank_reg >= CNT_W'(tmlux_pkg::DROP_LOW))
                    && (rank_reg < CNT_W'(CAL_SAMPLES - tmlux_pkg::DROP_HIGH));
    assign sum_add   = keep_cand ? (sum_reg + SUM_W'(cand_reg)) : sum_reg;

    // Restoring divider: one quotient bit per cycle.
    assign rem_sh = {rem_reg, dq_reg[VW-1]};
    assign q_bit  = (rem_sh >= {1'b0, dvsr_reg});
    assign quot   = {dq_reg[VW-2:0], q_bit};

    assign res_load = (state_reg == ST_DONE) && (!res_valid_reg || res.ready);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cal_next    = cal_reg;
        target_next = target_reg;
        ctr_next    = ctr_reg;
        ci_next     = ci_reg;
        step_next   = step_reg;
        rank_next   = rank_reg;
        cand_next   = cand_reg;
        sum_next    = sum_reg;
        mplr_next   = mplr_reg;
        dq_next     = dq_reg;
        rem_next    = rem_reg;
        dvsr_next   = dvsr_reg;
        kind_next   = kind_reg;
        err_next    = err_reg;

        if (cfg.valid)
        begin
            target_next = cfg.data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (smp_acc)
                begin
                    if (smp.data.kind == tmlux_pkg::KIND_CAL)
                    begin
                        if (count_reg == CNT_W'(CAL_SAMPLES - 1))
                        begin
                            // Store full: start ranking from the head entry
                            count_next = '0;
                            ci_next    = '0;
                            step_next  = '0;
                            rank_next  = '0;
                            sum_next   = '0;
                            state_next = ST_RANK;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (cal_reg == '0)
                    begin
                        // No calibration yet: flag the word and skip the arithmetic
                        dq_next    = '0;
                        kind_next  = tmlux_pkg::KIND_LUX;
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mplr_next  = smp.data.sample;
                        dq_next    = '0;
                        ctr_next   = '0;
                        state_next = ST_MUL;
                    end
                end
            end

            ST_RANK:
            begin
                if (step_reg == '0)
                begin
                    cand_next = store_reg[0];
                    rank_next = '0;
                    step_next = step_reg + JW'(1);
                end
                else if (step_reg != JW'(CAL_SAMPLES))
                begin
                    if (smaller)
                    begin
                        rank_next = rank_reg + CNT_W'(1);
                    end
                    step_next = step_reg + JW'(1);
                end
                else
                begin
                    // Candidate back at the head: add it if its rank survives the trim
                    sum_next  = sum_add;
                    step_next = '0;
                    ci_next   = ci_reg + CNT_W'(1);
                    if (ci_reg == CNT_W'(CAL_SAMPLES - 1))
                    begin
                        dq_next    = VW'(sum_add);
                        rem_next   = '0;
                        dvsr_next  = SW'(KEEP);
                        ctr_next   = '0;
                        kind_next  = tmlux_pkg::KIND_CAL;
                        err_next   = 1'b0;
                        state_next = ST_DIV;
                    end
                end
            end

            ST_MUL:
            begin
                // Shift-add, multiplier bits taken most significant first
                dq_next   = {dq_reg[VW-2:0], 1'b0}
                          + (mplr_reg[SW-1] ? VW'(target_reg) : '0);
                mplr_next = {mplr_reg[SW-2:0], 1'b0};
                ctr_next  = ctr_reg + tmlux_pkg::CTR_W'(1);
                if (ctr_reg == tmlux_pkg::CTR_W'(SW - 1))
                begin
                    rem_next   = '0;
                    dvsr_next  = cal_reg;
                    ctr_next   = '0;
                    kind_next  = tmlux_pkg::KIND_LUX;
                    err_next   = 1'b0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                dq_next  = quot;
                rem_next = q_bit ? SW'(rem_sh - {1'b0, dvsr_reg}) : rem_sh[SW-1:0];
                ctr_next = ctr_reg + tmlux_pkg::CTR_W'(1);
                if (ctr_reg == tmlux_pkg::CTR_W'(VW - 1))
                begin
                    if (kind_reg == tmlux_pkg::KIND_CAL)
                    begin
                        cal_next = quot[SW-1:0];
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hold until the result register is free
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register
    always_comb
    begin
        res_word_next = res_word_reg;
        if (res_load)
        begin
            res_word_next.result_kind = kind_reg;
            res_word_next.value       = dq_reg;
            res_word_next.error       = err_reg;
        end

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_word_reg;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cal_reg       <= '0;
            target_reg    <= tmlux_pkg::TARGET_W'(1);
            ctr_reg       <= '0;
            ci_reg        <= '0;
            step_reg      <= '0;
            rank_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cal_reg       <= cal_next;
            target_reg    <= target_next;
            ctr_reg       <= ctr_next;
            ci_reg        <= ci_next;
            step_reg      <= step_next;
            rank_reg      <= rank_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers and the sample ring
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        cand_reg     <= cand_next;
        sum_reg      <= sum_next;
        mplr_reg     <= mplr_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        dvsr_reg     <= dvsr_next;
        kind_reg     <= kind_next;
        err_reg      <= err_next;
        res_word_reg <= res_word_next;

        // Advance the ring: new word enters at the tail, or the head wraps round
        if (shift_in || rotate)
        begin
            for (int k = 0; k < CAL_SAMPLES - 1; k++)
            begin
                store_reg[k] <= store_reg[k+1];
            end
            store_reg[CAL_SAMPLES-1] <= shift_in ? smp.data.sample : store_reg[0];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.data.error) |-> (res.data.value == '0))
        else $error("error word carries a non-zero value");

    a_cal_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.data.result_kind == tmlux_pkg::KIND_CAL)) |-> !res.data.error)
        else $error("calibration word flagged as error");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAL_SAMPLES - 1))
        else $error("sample count past store depth");

    a_lux_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (smp.valid && smp.ready && (smp.data.kind == tmlux_pkg::KIND_LUX)) |=> !smp.ready)
        else $error("measurement word did not occupy the sequencer");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trimmed-mean lux scaler. A queue-fed driver and
// a monitor run the sample and result channels with random gaps. A local
// predictor of the store, the trimmed mean and the lux scaling checks each
// result word, field by field and in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CAL_N         = 10;         // store depth of the instance
    localparam int SETTLE_CYCLES = 200;        // longer than the fill job
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_WORDS   = 184;        // six random phases, about 1100 words

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tmlux_chan_if #(.payload_t(tmlux_pkg::in_word_t))  smp_if ();
    tmlux_chan_if #(.payload_t(tmlux_pkg::out_word_t)) res_if ();
    tmlux_chan_if #(.payload_t(tmlux_pkg::target_t))   cfg_if ();

    trimmed_mean_calibrated_lux_scaler #(.CAL_SAMPLES(CAL_N)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .smp   (smp_if.sink),
        .res   (res_if.source),
        .cfg   (cfg_if.sink)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the store, its fill level, the held
    // calibration value and the lux target as last written.
    // ------------------------------------------------------------------------
    tmlux_pkg::sample_t   cal_store [CAL_N];
    int                   cal_fill;
    tmlux_pkg::sample_t   cal_level;
    tmlux_pkg::target_t   lux_target_now;

    tmlux_pkg::in_word_t  pending_words [$];      // words waiting for the driver
    tmlux_pkg::out_word_t expected_results [$];   // predicted result words, oldest first

    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   mismatches;
    int                   words_sent;
    int                   cal_results;
    int                   lux_results;
    int                   flagged_results;
    int                   targets_written;
    int                   cycles;
    tmlux_pkg::out_word_t want;

    // Rank a copy of the store, drop the three lowest and two highest, and
    // average what is left with truncation.
    function automatic tmlux_pkg::sample_t trimmed_level();
        tmlux_pkg::sample_t ranked [CAL_N];
        tmlux_pkg::sample_t hold;
        int                 j;
        logic [31:0]        sum;
        sum = '0;
        for (int i = 0; i < CAL_N; i++)
            ranked[i] = cal_store[i];
        for (int i = 1; i < CAL_N; i++)
        begin
            hold = ranked[i];
            j = i;
            while (j > 0 && ranked[j-1] > hold)
            begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = hold;
        end
        for (int i = tmlux_pkg::DROP_LOW; i < CAL_N - tmlux_pkg::DROP_HIGH; i++)
            sum += ranked[i];
        return tmlux_pkg::sample_t'(
            sum / (CAL_N - tmlux_pkg::DROP_LOW - tmlux_pkg::DROP_HIGH));
    endfunction

    // Advance the predictor by one accepted sample word; queue any result.
    function automatic void calibrate_or_scale(input tmlux_pkg::in_word_t w);
        tmlux_pkg::out_word_t r;
        tmlux_pkg::value_t    product;
        r = '0;
        if (w.kind == tmlux_pkg::KIND_CAL)
        begin
            if (cal_fill >= CAL_N)
                cal_fill = 0;
            cal_store[cal_fill] = w.sample;
            cal_fill++;
            if (cal_fill == CAL_N)
            begin
                cal_level = trimmed_level();
                cal_fill = 0;
                r.result_kind = tmlux_pkg::KIND_CAL;
                r.value = tmlux_pkg::value_t'(cal_level);
                r.error = 1'b0;
                expected_results.push_back(r);
            end
        end
        else
        begin
            r.result_kind = tmlux_pkg::KIND_LUX;
            if (cal_level == '0)
            begin
                // no calibration yet, or it averaged to zero: flag it
                r.value = '0;
                r.error = 1'b1;
            end
            else
            begin
                product = tmlux_pkg::value_t'(w.sample)
                        * tmlux_pkg::value_t'(lux_target_now);
                r.value = product / tmlux_pkg::value_t'(cal_level);
                r.error = 1'b0;
            end
            expected_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present the next pending word, hold it until taken, and feed
    // the predictor at the edge where it is accepted.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            smp_if.valid <= 1'b0;
            smp_if.data  <= '0;
        end
        else
        begin
            if (smp_if.valid && smp_if.ready)
            begin
                calibrate_or_scale(smp_if.data);
                words_sent++;
            end
            // the slot is free once the held word went through, or none is held
            if (!smp_if.valid || smp_if.ready)
            begin
                if (pending_words.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    smp_if.valid <= 1'b1;
                    smp_if.data  <= pending_words.pop_front();
                end
                else
                    smp_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stall the result channel at random and compare each word taken
    // with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word with none predicted: kind %0d value %0d error %0d",
                             $time, res_if.data.result_kind, res_if.data.value,
                             res_if.data.error);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_if.data.result_kind !== want.result_kind)
                    begin
                        mismatches++;
                        $display("%0t: result_kind expected %0d actual %0d",
                                 $time, want.result_kind, res_if.data.result_kind);
                    end
                    if (res_if.data.value !== want.value)
                    begin
                        mismatches++;
                        $display("%0t: value expected %0d actual %0d",
                                 $time, want.value, res_if.data.value);
                    end
                    if (res_if.data.error !== want.error)
                    begin
                        mismatches++;
                        $display("%0t: error expected %0d actual %0d",
                                 $time, want.error, res_if.data.error);
                    end
                    if (want.result_kind == tmlux_pkg::KIND_CAL)
                        cal_results++;
                    else
                        lux_results++;
                    if (want.error)
                        flagged_results++;
                end
            end
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results outstanding",
                     $time, expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_word(input logic kind, input tmlux_pkg::sample_t s);
        tmlux_pkg::in_word_t w;
        w.kind   = kind;
        w.sample = s;
        pending_words.push_back(w);
    endfunction

    // Lean towards the ends of the range and small readings.
    function automatic tmlux_pkg::sample_t pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        else if (r < 20)
            return '1;
        else if (r < 40)
            return tmlux_pkg::sample_t'($urandom_range(255));
        return tmlux_pkg::sample_t'($urandom);
    endfunction

    // Mostly whole calibration rounds and runs of measurements; now and then
    // a stray calibration word that leaves the next round out of step.
    task automatic queue_random(input int count);
        int                 made;
        int                 r;
        int                 style;
        int                 spread;
        int                 s;
        tmlux_pkg::sample_t base;
        made = 0;
        while (made < count)
        begin
            r = $urandom_range(99);
            if (r < 40)
            begin
                style  = $urandom_range(19);
                base   = tmlux_pkg::sample_t'($urandom);
                spread = $urandom_range(1023);
                for (int k = 0; k < CAL_N; k++)
                begin
                    if (style == 0)
                        queue_word(tmlux_pkg::KIND_CAL, '0);     // zero calibration
                    else if (style == 1)
                        queue_word(tmlux_pkg::KIND_CAL, '1);
                    else if (style < 10)
                        queue_word(tmlux_pkg::KIND_CAL, pick_sample());
                    else
                    begin
                        // tight cluster around a random level
                        s = int'(base) + $urandom_range(spread);
                        if (s > 65535)
                            s = 65535;
                        queue_word(tmlux_pkg::KIND_CAL, tmlux_pkg::sample_t'(s));
                    end
                end
                made += CAL_N;
            end
            else if (r < 48)
            begin
                queue_word(tmlux_pkg::KIND_CAL, pick_sample());
                made++;
            end
            else
            begin
                style = $urandom_range(1, 4);
                for (int k = 0; k < style; k++)
                    queue_word(tmlux_pkg::KIND_LUX, pick_sample());
                made += style;
            end
        end
    endtask

    // Hold off until every queued word is taken and every result is back,
    // then let a fill job that gives no result run out.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || smp_if.valid ||
               expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Called at a rising edge while the block is idle.
    task automatic write_target(input tmlux_pkg::target_t t);
        cfg_if.data  <= t;
        cfg_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        lux_target_now = t;
        targets_written++;
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------
    initial
    begin
        tmlux_pkg::target_t phase_target [6];

        smp_if.valid = 1'b0;
        smp_if.data  = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        cal_fill        = 0;
        cal_level       = '0;
        lux_target_now  = tmlux_pkg::target_t'(1);
        send_idle_pct   = 31;
        recv_idle_pct   = 64;
        mismatches      = 0;
        words_sent      = 0;
        cal_results     = 0;
        lux_results     = 0;
        flagged_results = 0;
        targets_written = 0;
        cycles          = 0;

        phase_target[0] = tmlux_pkg::target_t'(1);
        phase_target[1] = '1;
        phase_target[2] = tmlux_pkg::target_t'($urandom_range(1, 65535));
        phase_target[3] = '0;              // below the stated range
        phase_target[4] = tmlux_pkg::target_t'($urandom_range(1, 65535));
        phase_target[5] = '1;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, target at its reset value: measure before any calibration,
        // then a round with ties and both extremes, then scale the extremes.
        queue_word(tmlux_pkg::KIND_LUX, '0);
        queue_word(tmlux_pkg::KIND_LUX, '1);
        queue_word(tmlux_pkg::KIND_CAL, '1);
        queue_word(tmlux_pkg::KIND_CAL, '0);
        queue_word(tmlux_pkg::KIND_CAL, '1);
        queue_word(tmlux_pkg::KIND_CAL, '0);
        for (int k = 1; k <= 5; k++)
            queue_word(tmlux_pkg::KIND_CAL, tmlux_pkg::sample_t'(k));
        queue_word(tmlux_pkg::KIND_CAL, '1);
        queue_word(tmlux_pkg::KIND_LUX, '1);
        queue_word(tmlux_pkg::KIND_LUX, '0);
        queue_word(tmlux_pkg::KIND_LUX, tmlux_pkg::sample_t'(1));
        wait_drained();

        // Largest target over a calibration of one: the widest lux value.
        write_target('1);
        @(negedge clk);
        for (int k = 0; k < CAL_N; k++)
            queue_word(tmlux_pkg::KIND_CAL, tmlux_pkg::sample_t'(1));
        queue_word(tmlux_pkg::KIND_LUX, '1);
        wait_drained();

        // Random phases: receiver-heavy idling, then sender-heavy, then none.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_target(phase_target[ph]);
            @(negedge clk);
            send_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 64 : 0;
            recv_idle_pct = (ph < 2) ? 64 : (ph < 4) ? 31 : 0;
            queue_random(PHASE_WORDS);
            wait_drained();
        end

        if (expected_results.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d predicted results never arrived",
                     $time, expected_results.size());
        end

        $display("Covered %0d sample words: %0d calibration and %0d lux results, %0d flagged.",
                 words_sent, cal_results, lux_results, flagged_results);
        $display("lux_target written %0d times, 0, 1 and 65535 among the settings.",
                 targets_written);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
